FILE: hw/rtl/rsc_pkg.sv
// Shared types, character codes and helpers of the radix string converter.
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_RADIX  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_RADIX = 1'd1;

  localparam logic [RADIX_W-1:0] IN_RADIX_RST  = 6'd10;
  localparam logic [RADIX_W-1:0] OUT_RADIX_RST = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A_M10 = 8'h37;  // 'A' - 10

  typedef struct packed {
    logic accept;     // fold the input character into the accumulator
    logic div_load;   // start conversion of the accumulator
    logic div_step;   // one restoring division bit
    logic dig_store;  // write remainder digit, start next division
    logic sign_load;  // load '-' into the output register
    logic rd_issue;   // read the next digit, most significant first
    logic dig_load;   // load the read digit into the output register
    logic str_clear;  // return string state to its reset values
  } rsc_cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a beat this cycle
    logic div_last;   // current division step is the final bit
    logic conv_stop;  // quotient is zero or digit store is full
    logic neg;        // sign was set by a leading '-'
    logic cnt_zero;   // no digits left to read
  } rsc_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] v);
    logic [CHAR_W-1:0] w;
    w = CHAR_W'(v);
    return (v <= DIGIT_W'(9)) ? (w + CH_ZERO) : (w + CH_A_M10);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rsc_in_if.sv
// Input character channel: valid/ready with character and end-of-string flag.
`timescale 1ns / 1ps
`default_nettype none

interface rsc_in_if;
  logic                       valid;
  logic                       ready;
  logic [rsc_pkg::CHAR_W-1:0] in_char;
  logic                       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rsc_out_if.sv
// Output character channel: valid/ready with character and end-of-string flag.
`timescale 1ns / 1ps
`default_nettype none

interface rsc_out_if;
  logic                       valid;
  logic                       ready;
  logic [rsc_pkg::CHAR_W-1:0] out_char;
  logic                       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rsc_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 32
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rsc_dp.sv
// Datapath: accumulator, radix registers, serial divider, digit store, output register.
`timescale 1ns / 1ps
`default_nettype none

module rsc_dp #(
  parameter int unsigned ACC_BITS   = 32,
  parameter int unsigned MAX_DIGITS = 32
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [rsc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [rsc_pkg::RADIX_W-1:0]        cfg_data_i,
  input  wire  [rsc_pkg::CHAR_W-1:0]         in_char_i,
  input  wire                                out_ready_i,
  output logic                               out_valid_o,
  output logic [rsc_pkg::CHAR_W-1:0]         out_char_o,
  output logic                               out_last_o,
  input  wire  rsc_pkg::rsc_cmd_t            cmd_i,
  output rsc_pkg::rsc_sts_t                  sts_o
);

  localparam int unsigned RW    = rsc_pkg::RADIX_W;
  localparam int unsigned DW    = rsc_pkg::DIGIT_W;
  localparam int unsigned PW    = ACC_BITS + RW;
  localparam int unsigned BW    = $clog2(ACC_BITS);
  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned AW    = $clog2(MAX_DIGITS);

  logic [RW-1:0]       in_radix_q, in_radix_d;
  logic [RW-1:0]       out_radix_q, out_radix_d;
  logic [ACC_BITS-1:0] acc_q, acc_d;
  logic                first_q, first_d;
  logic                neg_q, neg_d;
  logic [ACC_BITS-1:0] quo_q, quo_d;
  logic [DW-1:0]       rem_q, rem_d;
  logic [BW-1:0]       bit_cnt_q, bit_cnt_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic [rsc_pkg::CHAR_W-1:0] out_char_q, out_char_d;
  logic                out_last_q, out_last_d;

  logic                is_digit;
  logic                is_minus;
  logic [8:0]          dval;
  logic [PW-1:0]       prod;
  logic [ACC_BITS-1:0] acc_mac;
  logic [RW-1:0]       r_eff;
  logic [DW:0]         trial;
  logic                ge;
  logic [CNT_W-1:0]    cnt_m1;
  logic [DW-1:0]       ram_rdata;

  // digit value, wrapping below 'A' - 10 like the accumulator does
  assign is_digit = (in_char_i >= rsc_pkg::CH_ZERO) && (in_char_i <= rsc_pkg::CH_NINE);
  assign is_minus = (in_char_i == rsc_pkg::CH_MINUS);
  assign dval     = is_digit ? ({1'b0, in_char_i} - {1'b0, rsc_pkg::CH_ZERO})
                             : ({1'b0, in_char_i} - {1'b0, rsc_pkg::CH_A_M10});
  assign prod     = PW'(acc_q) * PW'(in_radix_q);
  assign acc_mac  = prod[ACC_BITS-1:0] + ACC_BITS'($signed(dval));

  // restoring division, one quotient bit per cycle
  assign r_eff = (out_radix_q < rsc_pkg::RADIX_MIN) ? rsc_pkg::RADIX_MIN : out_radix_q;
  assign trial = {rem_q, quo_q[ACC_BITS-1]};
  assign ge    = (trial >= {1'b0, r_eff});
  assign cnt_m1 = cnt_q - CNT_W'(1);

  always_comb begin
    in_radix_d  = in_radix_q;
    out_radix_d = out_radix_q;
    acc_d       = acc_q;
    first_d     = first_q;
    neg_d       = neg_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    bit_cnt_d   = bit_cnt_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        rsc_pkg::REG_IN_RADIX:  in_radix_d  = cfg_data_i;
        rsc_pkg::REG_OUT_RADIX: out_radix_d = cfg_data_i;
        default: ;
      endcase
    end

    if (cmd_i.accept) begin
      if (is_minus) begin
        if (first_q) begin
          neg_d = 1'b1;
        end
      end else begin
        acc_d = acc_mac;
      end
      first_d = 1'b0;
    end

    if (cmd_i.div_load) begin
      quo_d     = acc_q;
      rem_d     = '0;
      bit_cnt_d = '0;
      cnt_d     = '0;
    end

    if (cmd_i.div_step) begin
      rem_d     = ge ? DW'(trial - {1'b0, r_eff}) : trial[DW-1:0];
      quo_d     = {quo_q[ACC_BITS-2:0], ge};
      bit_cnt_d = bit_cnt_q + BW'(1);
    end

    if (cmd_i.dig_store) begin
      cnt_d     = cnt_q + CNT_W'(1);
      rem_d     = '0;
      bit_cnt_d = '0;
    end

    if (cmd_i.rd_issue) begin
      cnt_d = cnt_m1;
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.sign_load) begin
      out_valid_d = 1'b1;
      out_char_d  = rsc_pkg::CH_MINUS;
      out_last_d  = 1'b0;
    end
    if (cmd_i.dig_load) begin
      out_valid_d = 1'b1;
      out_char_d  = rsc_pkg::digit_char(ram_rdata);
      out_last_d  = (cnt_q == '0);
    end

    if (cmd_i.str_clear) begin
      acc_d   = '0;
      first_d = 1'b1;
      neg_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_radix_q  <= rsc_pkg::IN_RADIX_RST;
      out_radix_q <= rsc_pkg::OUT_RADIX_RST;
      acc_q       <= '0;
      first_q     <= 1'b1;
      neg_q       <= 1'b0;
      bit_cnt_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_radix_q  <= in_radix_d;
      out_radix_q <= out_radix_d;
      acc_q       <= acc_d;
      first_q     <= first_d;
      neg_q       <= neg_d;
      bit_cnt_q   <= bit_cnt_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  rsc_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_DIGITS)
  ) u_digit_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.dig_store),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (rem_q),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (cnt_m1[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.div_last  = (bit_cnt_q == BW'(ACC_BITS - 1));
  assign sts_o.conv_stop = (quo_q == '0) || (cnt_q == CNT_W'(MAX_DIGITS - 1));
  assign sts_o.neg       = neg_q;
  assign sts_o.cnt_zero  = (cnt_q == '0);

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rsc_ctrl.sv
// Controller: sequences accumulation, digit division and digit output.
`timescale 1ns / 1ps
`default_nettype none

module rsc_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  wire                in_last_i,
  output logic               in_ready_o,
  input  wire  rsc_pkg::rsc_sts_t sts_i,
  output rsc_pkg::rsc_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_SIGN  = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_WAIT  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (in_last_i) begin
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.dig_store = 1'b1;
        if (sts_i.conv_stop) begin
          state_d = sts_i.neg ? S_SIGN : S_RD;
        end else begin
          state_d = S_DIV;
        end
      end
      S_SIGN: begin
        if (sts_i.out_free) begin
          cmd_o.sign_load = 1'b1;
          state_d         = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_WAIT;
      end
      S_WAIT: begin
        if (sts_i.out_free) begin
          cmd_o.dig_load = 1'b1;
          if (sts_i.cnt_zero) begin
            cmd_o.str_clear = 1'b1;
            state_d         = S_IDLE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/radix_string_converter.sv
// Top level of the radix string converter: controller, datapath and checks.
// Usage:
//   in_ch takes one ASCII character per beat; in_last marks the end of the
//   string. Digits '0'-'9' count as c-'0', every other character as c-'A'+10
//   without checking; a '-' adds nothing and sets the sign only as the first
//   character. The accumulator wraps modulo 2^ACC_BITS.
//   On the last character the value is converted to output_radix (below two
//   reads as two) and sent on out_ch: '-' if signed, then the digits most
//   significant first, out_last on the final digit. At most MAX_DIGITS digits
//   are kept (the least significant).
// Timing:
//   A character without in_last keeps the converter idle, and a new one is
//   taken every cycle. The last character loads the bit-serial divider, which
//   divides bit by bit and stores a remainder digit, once per digit; each output
//   beat is then a digit-store read and an output register load, after the
//   sign beat if signed. in_ch is not ready during conversion and output.
// Stalls and reset:
//   A stalled out_ch holds the output register and the sequencer waits.
//   Reset sets input_radix to 10, output_radix to 2 and clears the string state; cfg_we_i
//   writes a register (index 0 input, 1 output); the user must write only while idle, not enforced.
`timescale 1ns / 1ps
`default_nettype none

module radix_string_converter #(
  parameter int unsigned ACC_BITS   = 32,
  parameter int unsigned MAX_DIGITS = 32
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  rsc_in_if.sink                        in_ch,
  rsc_out_if.source                     out_ch,
  input  wire                           cfg_we_i,
  input  wire  [rsc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire  [rsc_pkg::RADIX_W-1:0]   cfg_data_i
);

  rsc_pkg::rsc_cmd_t cmd;
  rsc_pkg::rsc_sts_t sts;
  logic              in_ready;

  // sequencer: accumulation, division per digit, output of digits
  rsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_last_i  (in_ch.in_last),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: multiply-add accumulator, serial divider, digit store, output beat
  rsc_dp #(
    .ACC_BITS   (ACC_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_char_i   (in_ch.in_char),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_char_o  (out_ch.out_char),
    .out_last_o  (out_ch.out_last),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  assign in_ch.ready = in_ready;

`ifndef SYNTHESIS
  // a final character stops intake; intake resumes once the last digit is loaded for output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready && in_ch.in_last) |=> !in_ch.ready)
    else $error("input taken during conversion");

  // never overwrite an output beat that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.dig_load || cmd.sign_load) |-> sts.out_free)
    else $error("output register overwritten");

  // digit store is never written in the same cycle as a read or an input intake
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.dig_store |-> !in_ch.ready && !cmd.rd_issue)
    else $error("digit store write collides with read or intake");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_radix_string_converter.sv
// Self-checking bench for the radix string converter: directed and random number strings.
`timescale 1ns / 1ps
module tb_radix_string_converter;

  localparam int unsigned CHAR_W    = rsc_pkg::CHAR_W;
  localparam int unsigned CFG_IDX_W = rsc_pkg::CFG_IDX_W;
  localparam int unsigned RADIX_W   = rsc_pkg::RADIX_W;
  localparam int unsigned DIGIT_W   = rsc_pkg::DIGIT_W;

  localparam int unsigned NUM_BITS      = 32;         // accumulator width of the dut
  localparam int unsigned NUM_DIGITS    = 32;         // digit store depth of the dut
  localparam int unsigned DEC_DIGITS    = 10;         // digit values below this print as '0'..'9'
  localparam int unsigned MAX_RADIX     = 36;
  localparam int unsigned PHASE_CHARS   = 47;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 1200;
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned MAX_ERR_LINES = 40;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [RADIX_W-1:0]   cfg_data;

  rsc_in_if  in_bus ();
  rsc_out_if out_bus ();

  radix_string_converter dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always #10 clk = ~clk;

  // Characters waiting to be driven, and converted characters still owed by the dut.
  char_beat_t pending_chars[$];
  char_beat_t owed_chars[$];

  // Own copy of the conversion state and the two radix registers.
  logic [NUM_BITS-1:0] acc_value;
  bit                  first_char;
  bit                  minus_seen;
  logic [RADIX_W-1:0]  in_radix;
  logic [RADIX_W-1:0]  out_radix;

  // Traffic shaping: set at rising edges, read (and counted down or cleared) by the falling-edge drivers.
  int unsigned send_idle_pct = 0;
  int unsigned rx_stall_pct  = 0;
  int unsigned rx_hold_left  = 0;
  bit          in_taken      = 1'b0;

  int unsigned n_queued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_beats    = 0;
  int unsigned n_strings  = 0;
  int unsigned n_settings = 1;
  int unsigned n_errors   = 0;
  int unsigned cycles     = 0;
  char_beat_t  got_beat;
  char_beat_t  want_beat;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    n_errors++;
    if (n_errors <= MAX_ERR_LINES)
      $display("[%0t] mismatch on %s: got 'h%0h, expected 'h%0h", $time, what, got, want);
  endtask

  // Fold one accepted character into the accumulator; on the end of the string,
  // expand the value in the output radix and queue the characters it must produce.
  task automatic convert_char(input logic [CHAR_W-1:0] ch, input logic last);
    logic [NUM_BITS-1:0] d;
    logic [NUM_BITS-1:0] v;
    logic [NUM_BITS-1:0] base;
    logic [DIGIT_W-1:0]  digs [NUM_DIGITS];
    int                  n;
    char_beat_t          b;
    if (ch == rsc_pkg::CH_MINUS) begin
      // only a leading minus sets the sign; any other one is skipped
      if (first_char) minus_seen = 1'b1;
    end else begin
      // letters and junk are not checked: everything outside '0'..'9' is c - 'A' + 10
      if (ch >= rsc_pkg::CH_ZERO && ch <= rsc_pkg::CH_NINE)
        d = NUM_BITS'(ch) - NUM_BITS'(rsc_pkg::CH_ZERO);
      else d = NUM_BITS'(ch) - NUM_BITS'(rsc_pkg::CH_A_M10);
      acc_value = acc_value * NUM_BITS'(in_radix) + d;
    end
    first_char = 1'b0;
    if (last) begin
      // an output radix of 0 or 1 divides by two
      base = (out_radix < rsc_pkg::RADIX_MIN) ? NUM_BITS'(rsc_pkg::RADIX_MIN)
                                              : NUM_BITS'(out_radix);
      v    = acc_value;
      n    = 0;
      do begin
        digs[n] = DIGIT_W'(v % base);
        n++;
        v = v / base;
      end while (v != 0 && n < NUM_DIGITS);
      if (minus_seen) begin
        b.ch   = rsc_pkg::CH_MINUS;
        b.last = 1'b0;
        owed_chars.push_back(b);
      end
      for (int i = n - 1; i >= 0; i--) begin
        // radices above 36 run past 'Z' on purpose
        b.ch   = (digs[i] < DEC_DIGITS) ? rsc_pkg::CH_ZERO + CHAR_W'(digs[i])
                                        : rsc_pkg::CH_A_M10 + CHAR_W'(digs[i]);
        b.last = (i == 0);
        owed_chars.push_back(b);
      end
      acc_value  = '0;
      first_char = 1'b1;
      minus_seen = 1'b0;
      n_strings++;
    end
  endtask

  task automatic push_char(input logic [CHAR_W-1:0] ch, input logic last);
    char_beat_t b;
    b.ch   = ch;
    b.last = last;
    pending_chars.push_back(b);
    n_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  // A digit character that is legal in the current input radix, or any of
  // '0'..'Z' when the radix is outside 2..36.
  function automatic logic [CHAR_W-1:0] radix_digit();
    int unsigned v;
    if (in_radix >= rsc_pkg::RADIX_MIN && in_radix <= MAX_RADIX)
      v = $urandom_range(in_radix - 1);
    else v = $urandom_range(MAX_RADIX - 1);
    return (v < DEC_DIGITS) ? rsc_pkg::CH_ZERO + CHAR_W'(v) : rsc_pkg::CH_A_M10 + CHAR_W'(v);
  endfunction

  // Mostly well-formed numbers, some raw byte noise, some strings with stray
  // minus signs and lowercase letters. A few long strings force wrap-around.
  task automatic push_random_string();
    int unsigned        kind;
    int unsigned        len;
    logic [CHAR_W-1:0]  ch;
    kind = $urandom_range(99);
    len  = ($urandom_range(9) == 0) ? $urandom_range(24, 11) : $urandom_range(8, 1);
    if (kind < 75) begin
      if ($urandom_range(1)) push_char(rsc_pkg::CH_MINUS, 1'b0);
      for (int i = 0; i < len; i++) push_char(radix_digit(), i == len - 1);
    end else if (kind < 90) begin
      for (int i = 0; i < len; i++) push_char(CHAR_W'($urandom_range(255)), i == len - 1);
    end else begin
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(2))
          0:       ch = rsc_pkg::CH_MINUS;
          1:       ch = CH_LOWER_A + CHAR_W'($urandom_range(25));
          default: ch = radix_digit();
        endcase
        push_char(ch, i == len - 1);
      end
    end
  endtask

  // Hold until every queued character is taken and every owed character has
  // come back, then let the dut settle. Both counts only move at rising edges.
  task automatic wait_drained();
    do @(negedge clk); while (n_accepted != n_queued || owed_chars.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RADIX_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we   <= 1'b0;
    if (idx == rsc_pkg::REG_IN_RADIX) in_radix = data;
    else out_radix = data;
  endtask

  // One phase: drain, set both radices while idle, pick the traffic shape, queue
  // about PHASE_CHARS characters of whole strings.
  task automatic run_phase(input logic [RADIX_W-1:0] in_r, input logic [RADIX_W-1:0] out_r,
                           input int unsigned send_pct, input int unsigned stall_pct,
                           input int unsigned hold_cycles);
    int unsigned start;
    wait_drained();
    write_reg(rsc_pkg::REG_IN_RADIX, in_r);
    write_reg(rsc_pkg::REG_OUT_RADIX, out_r);
    n_settings++;
    @(posedge clk);
    send_idle_pct = send_pct;
    rx_stall_pct  = stall_pct;
    rx_hold_left  = hold_cycles;
    start = n_queued;
    while (n_queued - start < PHASE_CHARS) push_random_string();
  endtask

  // Driver: present a new character only once the previous one was taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_bus.valid   <= 1'b1;
        in_bus.in_char <= pending_chars[0].ch;
        in_bus.in_last <= pending_chars[0].last;
        void'(pending_chars.pop_front());
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // Receiver: a long hold-off when asked for, random stalls otherwise.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Monitor: predict on each input beat, check each output beat, watch the clock.
  always @(posedge clk) begin
    cycles++;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        convert_char(in_bus.in_char, in_bus.in_last);
        n_accepted++;
        in_taken = 1'b1;
      end
      if (out_bus.valid && out_bus.ready) begin
        got_beat.ch   = out_bus.out_char;
        got_beat.last = out_bus.out_last;
        n_beats++;
        if (owed_chars.size() == 0) begin
          report_mismatch("unexpected output beat", got_beat.ch, 0);
        end else begin
          want_beat = owed_chars.pop_front();
          if (got_beat.ch !== want_beat.ch)
            report_mismatch("out_char", got_beat.ch, want_beat.ch);
          if (got_beat.last !== want_beat.last)
            report_mismatch("out_last", got_beat.last, want_beat.last);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still owed", cycles,
               owed_chars.size());
      $display("tb_radix_string_converter: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = rsc_pkg::REG_IN_RADIX;
    cfg_data       = '0;
    in_bus.valid   = 1'b0;
    in_bus.in_char = '0;
    in_bus.in_last = 1'b0;
    out_bus.ready  = 1'b0;
    in_radix       = rsc_pkg::IN_RADIX_RST;
    out_radix      = rsc_pkg::OUT_RADIX_RST;
    acc_value      = '0;
    first_char     = 1'b1;
    minus_seen     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed strings at the reset radices (decimal in, binary out): zero,
    // a signed value, a lone minus, a minus in the middle, a doubled minus,
    // the full 32-bit value, and unchecked bytes at both ends of the range.
    @(posedge clk);
    push_text("0");
    push_text("-7");
    push_text("-");
    push_text("1-2");
    push_text("--");
    push_text("4294967295");
    push_char(8'hFF, 1'b1);
    push_char(8'h00, 1'b0);
    push_text("z#");

    // Random phases; each drain between phases also pauses the sender until
    // nothing is owed. Radix extremes come first, the long receiver hold-off
    // sits in a phase with a busy sender so the dut backs up into its input.
    run_phase(6'd36, 6'd36, 0, 0, 0);
    run_phase(6'd2, 6'd63, 83, 0, 0);
    run_phase(6'd0, 6'd1, 0, 83, 0);
    run_phase(6'd1, 6'd0, 9, 9, 0);
    run_phase(6'd63, 6'd37, 0, 0, 600);
    run_phase(6'd16, 6'd10, 83, 0, 0);
    run_phase(RADIX_W'($urandom_range(63)), RADIX_W'($urandom_range(63)), 0, 83, 0);
    run_phase(6'd10, 6'd2, 9, 9, 300);
    run_phase(RADIX_W'($urandom_range(36, 2)), RADIX_W'($urandom_range(36, 2)), 0, 0, 0);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (owed_chars.size() != 0)
      report_mismatch("characters never sent", 0, owed_chars.size());

    $display("converted %0d strings: %0d characters in, %0d characters out, %0d radix settings",
             n_strings, n_accepted, n_beats, n_settings);
    $display("%0d cycles, %0d mismatches", cycles, n_errors);
    if (n_errors == 0) begin
      $display("tb_radix_string_converter: PASS");
    end else begin
      $display("tb_radix_string_converter: FAIL");
    end
    $finish;
  end

endmodule
